>>> src/aas_pkg.sv
`default_nettype none
package aas_pkg;

  localparam int unsigned SCORE_BITS_DEF = 24;
  localparam int unsigned TEMP_W         = 16;
  localparam int unsigned DIE_W          = 7;
  localparam int unsigned TBL_W          = 19;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned BOUND_W        = TEMP_W + TBL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWP_LIMIT = 2'd2;

  localparam logic [TEMP_W-1:0] INIT_TEMP_RST = 16'd10000;
  localparam logic [TEMP_W-1:0] ATT_LIMIT_RST = 16'd10000;
  localparam logic [TEMP_W-1:0] SWP_LIMIT_RST = 16'd1000;

  localparam logic [DIE_W-1:0] DIE_MIN = 7'd1;
  localparam logic [DIE_W-1:0] DIE_MAX = 7'd100;

  // -ln(die/100) in unsigned q3.16
  localparam logic [TBL_W-1:0] NEG_LN [101] = '{
    19'd0,
    19'd301804, 19'd256378, 19'd229806, 19'd210952, 19'd196328,
    19'd184380, 19'd174277, 19'd165526, 19'd157807, 19'd150902,
    19'd144656, 19'd138954, 19'd133708, 19'd128851, 19'd124330,
    19'd120100, 19'd116127, 19'd112381, 19'd108838, 19'd105476,
    19'd102279, 19'd99230,  19'd96317,  19'd93527,  19'd90852,
    19'd88282,  19'd85808,  19'd83425,  19'd81125,  19'd78904,
    19'd76755,  19'd74674,  19'd72657,  19'd70701,  19'd68801,
    19'd66955,  19'd65159,  19'd63412,  19'd61709,  19'd60050,
    19'd58432,  19'd56853,  19'd55310,  19'd53804,  19'd52331,
    19'd50891,  19'd49481,  19'd48101,  19'd46750,  19'd45426,
    19'd44128,  19'd42856,  19'd41607,  19'd40382,  19'd39180,
    19'd37999,  19'd36839,  19'd35699,  19'd34579,  19'd33477,
    19'd32394,  19'd31329,  19'd30280,  19'd29248,  19'd28232,
    19'd27231,  19'd26246,  19'd25275,  19'd24318,  19'd23375,
    19'd22445,  19'd21529,  19'd20625,  19'd19733,  19'd18854,
    19'd17985,  19'd17129,  19'd16283,  19'd15448,  19'd14624,
    19'd13810,  19'd13006,  19'd12211,  19'd11426,  19'd10651,
    19'd9884,   19'd9127,   19'd8378,   19'd7637,   19'd6905,
    19'd6181,   19'd5464,   19'd4756,   19'd4055,   19'd3362,
    19'd2675,   19'd1996,   19'd1324,   19'd659,    19'd0
  };

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] temp;
  } sched_info_t;

  typedef struct packed {
    logic pend_take;
    logic fold_take;
  } eval_fb_t;

  function automatic logic [TBL_W-1:0] neg_ln_lookup(input logic [DIE_W-1:0] die);
    logic [DIE_W-1:0] d;
    if (die < DIE_MIN) begin
      d = DIE_MIN;
    end else if (die > DIE_MAX) begin
      d = DIE_MAX;
    end else begin
      d = die;
    end
    return NEG_LN[d];
  endfunction

  // floor(t*95/100) = floor(floor(t*19/4)/5), divide by 5 via reciprocal
  function automatic logic [TEMP_W-1:0] cool_temp(input logic [TEMP_W-1:0] t);
    logic [20:0] x;
    logic [18:0] y;
    logic [37:0] p;
    x = 21'(t) * 21'd19;
    y = x[20:2];
    p = 38'(y) * 38'd419431;
    return p[36:21];
  endfunction

endpackage
`default_nettype wire

>>> src/annealing_acceptance_scheduler_unit.sv
// a result passes through the first stage register and then the output register after its request is accepted
// throughput: one request per cycle unless the output is stalled, set by the temperature and counter update loop
// the acceptance product temp * table value sits in the second register stage
// reset: temperature 10000, attempt limit 10000, swap limit 1000, counters cleared
// reset: both pipeline stages empty, no clearing pass
`default_nettype none
module annealing_acceptance_scheduler_unit import aas_pkg::*; #(
  parameter int unsigned SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [TEMP_W-1:0]    cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // current_score, candidate_score, die_value
  input  wire logic [((2*SCORE_BITS+DIE_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // accept, temperature
  output logic [((1+TEMP_W+7)/8)*8-1:0] m_axis_tdata,
  // done_res
  output logic                      m_axis_tuser
);

  localparam int unsigned IN_W  = ((2*SCORE_BITS+DIE_W+7)/8)*8;
  localparam int unsigned OUT_W = ((1+TEMP_W+7)/8)*8;

  logic                  acc;
  logic [SCORE_BITS-1:0] cur;
  logic [SCORE_BITS-1:0] cand;
  logic [DIE_W-1:0]      die;
  sched_info_t           info;
  eval_fb_t              fb;
  logic                  res_accept;
  logic [TEMP_W-1:0]     res_temp;
  logic [IN_W-1:0]       in_word;

  assign in_word = s_axis_tdata;
  assign cur     = in_word[SCORE_BITS-1:0];
  assign cand    = in_word[2*SCORE_BITS-1:SCORE_BITS];
  assign die     = in_word[2*SCORE_BITS+DIE_W-1:2*SCORE_BITS];
  assign acc     = s_axis_tvalid && s_axis_tready;

  aas_sched u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .fb_i        (fb),
    .info_o      (info)
  );

  aas_eval #(
    .SCORE_BITS (SCORE_BITS)
  ) u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .cur_i        (cur),
    .cand_i       (cand),
    .die_i        (die),
    .info_i       (info),
    .out_ready_i  (m_axis_tready),
    .in_ready_o   (s_axis_tready),
    .fb_o         (fb),
    .out_valid_o  (m_axis_tvalid),
    .out_accept_o (res_accept),
    .out_done_o   (m_axis_tuser),
    .out_temp_o   (res_temp)
  );

  assign m_axis_tdata = OUT_W'({res_temp, res_accept});

  // a finished run never accepts and reports zero temperature
  a_done_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0] && (m_axis_tdata[TEMP_W:1] == '0))
    else $error("done result with accept or temperature set");

  // an accepted request reaches the output through the first stage and output registers when not stalled
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing two cycles after request");

  // input side only stalls when both stages are occupied and output is stalled
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

>>> src/aas_sched.sv
`default_nettype none
module aas_sched import aas_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [TEMP_W-1:0]    cfg_wdata_i,
  input  wire logic                 acc_i,
  input  wire eval_fb_t             fb_i,
  output sched_info_t               info_o
);

  logic [TEMP_W-1:0] temp_q, temp_d;
  logic [TEMP_W-1:0] att_q, att_d;
  logic [TEMP_W-1:0] swap_q, swap_d;
  logic [TEMP_W-1:0] att_lim_q, att_lim_d;
  logic [TEMP_W-1:0] swap_lim_q, swap_lim_d;

  logic [TEMP_W-1:0] swap_inc;
  logic [TEMP_W-1:0] swap_base;
  logic              swap_ge;
  logic              cool;
  logic              done;
  logic [TEMP_W-1:0] temp_item;

  assign done      = (temp_q == '0);
  assign swap_inc  = swap_q + TEMP_W'(1);
  // swap count including the request still under evaluation
  assign swap_ge   = fb_i.pend_take ? (swap_inc >= swap_lim_q) : (swap_q >= swap_lim_q);
  assign cool      = (att_q >= att_lim_q) || swap_ge;
  assign temp_item = cool ? cool_temp(temp_q) : temp_q;
  assign swap_base = fb_i.fold_take ? swap_inc : swap_q;

  assign info_o.done = done;
  assign info_o.temp = done ? '0 : temp_item;

  always_comb begin
    temp_d     = temp_q;
    att_d      = att_q;
    swap_d     = swap_base;
    att_lim_d  = att_lim_q;
    swap_lim_d = swap_lim_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_INIT_TEMP: begin
          temp_d = cfg_wdata_i;
          att_d  = '0;
          swap_d = '0;
        end
        CFG_ATT_LIMIT: att_lim_d = cfg_wdata_i;
        CFG_SWP_LIMIT: swap_lim_d = cfg_wdata_i;
        default: ;
      endcase
    end else if (acc_i && !done) begin
      temp_d = temp_item;
      att_d  = cool ? TEMP_W'(1) : att_q + TEMP_W'(1);
      if (cool) begin
        swap_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= INIT_TEMP_RST;
      att_q      <= '0;
      swap_q     <= '0;
      att_lim_q  <= ATT_LIMIT_RST;
      swap_lim_q <= SWP_LIMIT_RST;
    end else begin
      temp_q     <= temp_d;
      att_q      <= att_d;
      swap_q     <= swap_d;
      att_lim_q  <= att_lim_d;
      swap_lim_q <= swap_lim_d;
    end
  end

endmodule
`default_nettype wire

>>> src/aas_eval.sv
`default_nettype none
module aas_eval import aas_pkg::*; #(
  parameter int unsigned SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  acc_i,
  input  wire logic [SCORE_BITS-1:0] cur_i,
  input  wire logic [SCORE_BITS-1:0] cand_i,
  input  wire logic [DIE_W-1:0]      die_i,
  input  wire sched_info_t           info_i,
  input  wire logic                  out_ready_i,
  output logic                       in_ready_o,
  output eval_fb_t                   fb_o,
  output logic                       out_valid_o,
  output logic                       out_accept_o,
  output logic                       out_done_o,
  output logic [TEMP_W-1:0]          out_temp_o
);

  localparam int unsigned LHS_W = SCORE_BITS + 16;
  localparam int unsigned CMP_W = (LHS_W > BOUND_W) ? LHS_W : BOUND_W;

  logic                  s1_valid_q;
  logic                  s1_done_q;
  logic [TEMP_W-1:0]     s1_temp_q;
  logic                  s1_strict_q;
  logic [SCORE_BITS-1:0] s1_delta_q;
  logic [TBL_W-1:0]      s1_tval_q;

  logic                  out_valid_q;
  logic                  out_accept_q;
  logic                  out_done_q;
  logic [TEMP_W-1:0]     out_temp_q;

  logic                  adv;
  logic [BOUND_W-1:0]    bound;
  logic [CMP_W-1:0]      lhs;
  logic [CMP_W-1:0]      rhs;
  logic                  take;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  assign bound = BOUND_W'(s1_temp_q) * BOUND_W'(s1_tval_q);
  assign lhs   = CMP_W'({s1_delta_q, 16'h0000});
  assign rhs   = CMP_W'(bound);
  assign take  = !s1_done_q && (s1_strict_q || ((s1_temp_q != '0) && (lhs <= rhs)));

  assign fb_o.pend_take = s1_valid_q && take;
  assign fb_o.fold_take = s1_valid_q && adv && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_done_q   <= info_i.done;
      s1_temp_q   <= info_i.temp;
      s1_strict_q <= cand_i < cur_i;
      s1_delta_q  <= cand_i - cur_i;
      s1_tval_q   <= neg_ln_lookup(die_i);
    end
    if (adv && s1_valid_q) begin
      out_accept_q <= take;
      out_done_q   <= s1_done_q;
      out_temp_q   <= s1_temp_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_accept_o = out_accept_q;
  assign out_done_o   = out_done_q;
  assign out_temp_o   = out_temp_q;

endmodule
`default_nettype wire

>>> tb/tb_anneal_checker.sv
module tb_anneal_checker import aas_pkg::*; #(
  parameter int unsigned SB    = SCORE_BITS_DEF,
  parameter int unsigned REQ_W = ((2*SCORE_BITS_DEF+DIE_W+7)/8)*8,
  parameter int unsigned RES_W = ((1+TEMP_W+7)/8)*8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [TEMP_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // current_score, candidate_score, die_value
  input  logic [REQ_W-1:0]     s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accept, temperature
  input  logic [RES_W-1:0]     m_axis_tdata,
  // done_res
  input  logic                 m_axis_tuser,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam logic [TEMP_W-1:0] START_TEMP  = 16'd10000;
  localparam logic [TEMP_W-1:0] START_ATT   = 16'd10000;
  localparam logic [TEMP_W-1:0] START_SWP   = 16'd1000;
  localparam logic [DIE_W-1:0]  DIE_LO      = 7'd1;
  localparam logic [DIE_W-1:0]  DIE_HI      = 7'd100;

  // -ln(die/100), unsigned q3.16
  localparam int unsigned NEG_LOG_Q16 [101] = '{
    0,
    301804, 256378, 229806, 210952, 196328, 184380, 174277, 165526, 157807, 150902,
    144656, 138954, 133708, 128851, 124330, 120100, 116127, 112381, 108838, 105476,
    102279, 99230, 96317, 93527, 90852, 88282, 85808, 83425, 81125, 78904,
    76755, 74674, 72657, 70701, 68801, 66955, 65159, 63412, 61709, 60050,
    58432, 56853, 55310, 53804, 52331, 50891, 49481, 48101, 46750, 45426,
    44128, 42856, 41607, 40382, 39180, 37999, 36839, 35699, 34579, 33477,
    32394, 31329, 30280, 29248, 28232, 27231, 26246, 25275, 24318, 23375,
    22445, 21529, 20625, 19733, 18854, 17985, 17129, 16283, 15448, 14624,
    13810, 13006, 12211, 11426, 10651, 9884, 9127, 8378, 7637, 6905,
    6181, 5464, 4756, 4055, 3362, 2675, 1996, 1324, 659, 0
  };

  typedef struct packed {
    logic              accept;
    logic              done;
    logic [TEMP_W-1:0] temp;
  } decision_t;

  logic [TEMP_W-1:0] attempt_lim_q = START_ATT;
  logic [TEMP_W-1:0] swap_lim_q    = START_SWP;
  logic [TEMP_W-1:0] temp_q        = START_TEMP;
  logic [TEMP_W-1:0] attempts_q    = '0;
  logic [TEMP_W-1:0] swaps_q       = '0;

  decision_t pending_decisions [$];
  decision_t got, want, predicted;
  int unsigned fails = 0;

  task automatic report_mismatch(input string msg);
    if (fails < 40) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fails++;
  endtask

  task automatic metropolis_predict(input logic [SB-1:0] cur, input logic [SB-1:0] cand,
                                    input logic [DIE_W-1:0] die_raw, output decision_t d);
    logic [DIE_W-1:0] die;
    logic [63:0]      delta;
    logic [63:0]      bound;
    logic             take;
    d    = '0;
    die  = die_raw;
    take = 1'b0;
    if (temp_q == '0) begin
      d.done = 1'b1;
    end else begin
      if (attempts_q >= attempt_lim_q || swaps_q >= swap_lim_q) begin
        temp_q     = TEMP_W'((32'(temp_q) * 32'd95) / 32'd100);
        attempts_q = '0;
        swaps_q    = '0;
      end
      if (die < DIE_LO) begin
        die = DIE_LO;
      end else if (die > DIE_HI) begin
        die = DIE_HI;
      end
      if (cand < cur) begin
        take = 1'b1;
      end else if (temp_q != '0) begin
        delta = 64'(cand) - 64'(cur);
        bound = 64'(temp_q) * 64'(NEG_LOG_Q16[die]);
        take  = (delta << 16) <= bound;
      end
      if (take) begin
        swaps_q = swaps_q + 1'b1;
      end
      attempts_q = attempts_q + 1'b1;
      d.accept   = take;
      d.temp     = temp_q;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attempt_lim_q = START_ATT;
      swap_lim_q    = START_SWP;
      temp_q        = START_TEMP;
      attempts_q    = '0;
      swaps_q       = '0;
      pending_decisions.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.accept = m_axis_tdata[0];
        got.temp   = m_axis_tdata[TEMP_W:1];
        got.done   = m_axis_tuser;
        if (pending_decisions.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: %p", got));
        end else begin
          want = pending_decisions.pop_front();
          if (got.accept !== want.accept) begin
            report_mismatch($sformatf("accept got %b want %b", got.accept, want.accept));
          end
          if (got.done !== want.done) begin
            report_mismatch($sformatf("done got %b want %b", got.done, want.done));
          end
          if (got.temp !== want.temp) begin
            report_mismatch($sformatf("temperature got %0d want %0d", got.temp, want.temp));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        metropolis_predict(s_axis_tdata[SB-1:0], s_axis_tdata[2*SB-1:SB],
                           s_axis_tdata[2*SB+DIE_W-1:2*SB], predicted);
        pending_decisions.push_back(predicted);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_INIT_TEMP: begin
            temp_q      = cfg_wdata_i;
            attempts_q  = '0;
            swaps_q     = '0;
          end
          CFG_ATT_LIMIT: begin
            attempt_lim_q = cfg_wdata_i;
          end
          CFG_SWP_LIMIT: begin
            swap_lim_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
    end
    pending_o    <= pending_decisions.size();
    fail_count_o <= fails;
  end

endmodule

>>> tb/tb_top.sv
module tb_top import aas_pkg::*;;

  localparam int unsigned SB    = SCORE_BITS_DEF;
  localparam int unsigned REQ_W = ((2*SB+DIE_W+7)/8)*8;
  localparam int unsigned RES_W = ((1+TEMP_W+7)/8)*8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [SB-1:0] SCORE_MAX = '1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_REQS    = 237;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i    = '0;
  logic [TEMP_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic [REQ_W-1:0]     s_axis_tdata  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 steady        = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [RES_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  int unsigned          fail_count;
  int unsigned          pending_reqs;

  annealing_acceptance_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tb_anneal_checker i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_reqs)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 31);
  end

  task automatic send_req(input logic [SB-1:0] cur, input logic [SB-1:0] cand,
                          input logic [DIE_W-1:0] die);
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= REQ_W'({die, cand, cur});
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_random_req();
    logic [SB-1:0]    cur;
    logic [SB-1:0]    cand;
    logic [DIE_W-1:0] die;
    int unsigned      shape;
    shape = $urandom_range(99);
    if (shape < 70) begin
      // near the acceptance bound, spread over many scales
      cur  = SB'($urandom_range(32'hEFFFFF));
      cand = cur + SB'($urandom_range((32'd1 << $urandom_range(20)) - 1));
    end else if (shape < 85) begin
      cur  = SB'($urandom);
      cand = SB'($urandom_range(32'(cur)));
    end else begin
      cur  = SB'($urandom);
      cand = SB'($urandom);
    end
    if ($urandom_range(99) < 90) begin
      die = DIE_W'($urandom_range(100, 1));
    end else begin
      die = DIE_W'($urandom_range(127));
    end
    send_req(cur, cand, die);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_reqs != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [TEMP_W-1:0] init_temp,
                              input logic [TEMP_W-1:0] att_lim,
                              input logic [TEMP_W-1:0] swp_lim);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_INIT_TEMP;
    cfg_wdata_i <= init_temp;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_ATT_LIMIT;
    cfg_wdata_i <= att_lim;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_SWP_LIMIT;
    cfg_wdata_i <= swp_lim;
    @(posedge clk_i);
    // unmapped index, must change nothing
    cfg_addr_i  <= CFG_UNUSED;
    cfg_wdata_i <= TEMP_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(19))
      0:             return '1;
      1:             return '0;
      2, 3, 4, 5, 6: return TEMP_W'($urandom_range(60, 1));
      default:       return TEMP_W'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [TEMP_W-1:0] pick_limit();
    case ($urandom_range(19))
      0:             return '0;
      1, 2:          return '1;
      3, 4, 5, 6, 7: return TEMP_W'($urandom_range(65535, 1));
      default:       return TEMP_W'($urandom_range(12, 1));
    endcase
  endfunction

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, temperature 10000
    send_req('0, '0, 7'd1);
    send_req(SCORE_MAX, '0, 7'd100);
    send_req('0, SCORE_MAX, 7'd1);
    send_req(SB'(100), SB'(100 + 6931), 7'd50);
    send_req(SB'(100), SB'(100 + 6932), 7'd50);
    send_req(SB'(7), SB'(8), 7'd100);
    send_req(SB'(7), SB'(7), 7'd100);
    send_req(SB'(0), SB'(46051), 7'd0);
    send_req(SB'(0), SB'(46052), 7'd1);
    send_req(SB'(5), SB'(5), 7'd127);
    send_req(SB'(5), SB'(6), 7'd101);
    send_req(SB'(24'h555555), SB'(24'hAAAAAA), 7'h2A);
    settle();

    // cooling down to zero, then finished
    program_regs(16'd1, 16'd3, 16'd2);
    send_req(SB'(9), SB'(9), 7'd60);
    send_req(SB'(9), SB'(9), 7'd60);
    send_req(SB'(9), SB'(9), 7'd60);
    send_req(SB'(9), SB'(3), 7'd60);
    send_req(SB'(9), SB'(3), 7'd60);
    settle();

    program_regs('0, 16'd5, 16'd5);
    send_req(SCORE_MAX, '0, 7'd1);
    send_req(SB'(4), SB'(4), 7'd100);
    settle();

    // zero limits cool on every step
    program_regs('1, '0, '0);
    send_req(SB'(0), SB'(150000), 7'd10);
    send_req(SB'(0), SB'(140000), 7'd10);
    send_req(SB'(8), SB'(2), 7'd99);
    settle();

    program_regs('1, '1, '1);
    send_req(SB'(0), SB'(301799), 7'd1);
    send_req(SB'(0), SB'(301800), 7'd1);
    send_req(SCORE_MAX, SCORE_MAX, 7'd100);
    settle();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_regs(pick_temp(), pick_limit(), pick_limit());
      steady <= (ph == 3);
      for (int unsigned n = 0; n < PHASE_REQS; n++) begin
        send_random_req();
      end
      settle();
    end

    if (fail_count == 0 && pending_reqs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
